>>> rtl/core/sdpb_pkg.sv
// Shared types, constants and arithmetic helpers of the straight-drive PID balancer.
`timescale 1ns / 1ps

package sdpb_pkg;

    // Field and datapath widths.
    localparam int TARGET_W   = 23;
    localparam int BASE_W     = 8;
    localparam int SLOW_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int DECAY_W    = 9;
    localparam int MIN_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;
    localparam int POS_W      = 24;
    localparam int VEL_W      = 12;
    localparam int ERR_W      = VEL_W + 1;
    localparam int DERIV_W    = ERR_W + 1;
    localparam int INTEG_W    = 32;
    localparam int SPEED_W    = 16;
    localparam int DRIVE_W    = 8;
    localparam int FRAC_W     = 8;
    localparam int OFFS_W     = 12;
    localparam int STEP_W     = OFFS_W + FRAC_W;
    localparam int CORR_W     = STEP_W + 1;
    localparam int PROD_P_W   = ERR_W + GAIN_W;
    localparam int PROD_I_W   = INTEG_W + GAIN_W;
    localparam int PROD_D_W   = DERIV_W + GAIN_W;
    localparam int SUM_W      = PROD_I_W + 1;
    localparam int DIST_W     = POS_W + 1;
    localparam int DPROD_W    = SPEED_W + DECAY_W;
    localparam int SCALED_W   = SPEED_W + 1;

    // Limits of the speed, the offset, the base speed and the error.
    localparam logic signed [SPEED_W-1:0] SPEED_LIM_Q = 16'sd32512;
    localparam logic signed [OFFS_W-1:0]  OFFS_LIM    = 12'sd1024;
    localparam logic signed [BASE_W-1:0]  BASE_MIN    = -8'sd127;
    localparam logic signed [BASE_W-1:0]  BASE_NEG    = -8'sd128;
    localparam logic signed [ERR_W-1:0]   ERR_LIM     = 13'sd2048;

    // Register reset values.
    localparam logic [TARGET_W-1:0]       TARGET_RST = '0;
    localparam logic signed [BASE_W-1:0]  BASE_RST   = '0;
    localparam logic [SLOW_W-1:0]         SLOW_RST   = 16'd374;
    localparam logic signed [GAIN_W-1:0]  PROP_RST   = 16'sd256;
    localparam logic signed [GAIN_W-1:0]  INTEG_RST  = '0;
    localparam logic signed [GAIN_W-1:0]  DERIV_RST  = '0;
    localparam logic [DECAY_W-1:0]        DECAY_RST  = 9'd235;
    localparam logic [MIN_W-1:0]          MIN_RST    = 7'd40;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_TICKS    = 3'd0,
        CFG_BASE_SPEED      = 3'd1,
        CFG_SLOW_ZONE_TICKS = 3'd2,
        CFG_PROP_GAIN       = 3'd3,
        CFG_INTEG_GAIN      = 3'd4,
        CFG_DERIV_GAIN      = 3'd5,
        CFG_DECAY_FACTOR    = 3'd6,
        CFG_MIN_SPEED       = 3'd7
    } t_cfg_idx;

    // Item operation codes.
    typedef enum logic {
        OP_START  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic signed [POS_W-1:0]  encoder_position;
        logic signed [VEL_W-1:0]  left_velocity;
        logic signed [VEL_W-1:0]  right_velocity;
    } t_in_item;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left_drive;
        logic signed [DRIVE_W-1:0] right_drive;
        logic signed [POS_W-1:0]   traveled_ticks;
        logic                      done_res;
    } t_out_item;

    typedef struct packed {
        logic [TARGET_W-1:0]       target_ticks;
        logic signed [BASE_W-1:0]  base_speed;
        logic [SLOW_W-1:0]         slow_zone_ticks;
        logic signed [GAIN_W-1:0]  prop_gain;
        logic signed [GAIN_W-1:0]  integ_gain;
        logic signed [GAIN_W-1:0]  deriv_gain;
        logic [DECAY_W-1:0]        decay_factor;
        logic [MIN_W-1:0]          min_speed;
    } t_cfg;

    // Hand-off from the error stage to the speed stage.
    typedef struct packed {
        t_op                        op;
        logic signed [POS_W-1:0]    traveled;
        logic                       slow;
        logic                       reached;
        logic signed [PROD_P_W-1:0] p_prop;
        logic signed [PROD_I_W-1:0] p_integ;
        logic signed [PROD_D_W-1:0] p_deriv;
    } t_mid;

    // Clamp a wide signed value to the speed range.
    function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [DPROD_W-1:0] v);
        logic signed [SPEED_W-1:0] res;
        if (v > DPROD_W'(SPEED_LIM_Q)) begin
            res = SPEED_LIM_Q;
        end else if (v < -DPROD_W'(SPEED_LIM_Q)) begin
            res = -SPEED_LIM_Q;
        end else begin
            res = SPEED_W'(v);
        end
        return res;
    endfunction

    // Scale a speed by the decay factor; keep the old speed if the result gets too slow.
    function automatic logic signed [SPEED_W-1:0] decay_one(
        input logic signed [SPEED_W-1:0] q,
        input logic [DECAY_W-1:0]        df,
        input logic [MIN_W-1:0]          min_sp
    );
        logic signed [DPROD_W-1:0]  prod;
        logic signed [DPROD_W-1:0]  adj;
        logic signed [SCALED_W-1:0] scaled;
        logic [SCALED_W-1:0]        mag;
        logic signed [SPEED_W-1:0]  res;
        prod = DPROD_W'(q) * $signed({1'b0, df});
        // Round toward zero before the shift.
        adj = prod[DPROD_W-1] ? prod + DPROD_W'((1 << FRAC_W) - 1) : prod;
        scaled = SCALED_W'(adj >>> FRAC_W);
        mag = scaled[SCALED_W-1] ? SCALED_W'(-scaled) : SCALED_W'(scaled);
        if ((mag >> FRAC_W) < SCALED_W'(min_sp)) begin
            res = q;
        end else begin
            res = sat_speed(DPROD_W'(scaled));
        end
        return res;
    endfunction

    // Integer part of a Q8.8 speed, truncated toward zero.
    function automatic logic signed [DRIVE_W-1:0] speed_to_drive(
        input logic signed [SPEED_W-1:0] q
    );
        logic signed [SPEED_W-1:0] adj;
        adj = q[SPEED_W-1] ? q + SPEED_W'((1 << FRAC_W) - 1) : q;
        return DRIVE_W'(adj >>> FRAC_W);
    endfunction

endpackage

>>> rtl/core/sdpb_cfg.sv
// Configuration register file of the straight-drive PID balancer.
`timescale 1ns / 1ps

module sdpb_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sdpb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sdpb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output sdpb_pkg::t_cfg                     o_cfg
);

    sdpb_pkg::t_cfg r_cfg;

    // Register writes, one register per transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_ticks    <= sdpb_pkg::TARGET_RST;
            r_cfg.base_speed      <= sdpb_pkg::BASE_RST;
            r_cfg.slow_zone_ticks <= sdpb_pkg::SLOW_RST;
            r_cfg.prop_gain       <= sdpb_pkg::PROP_RST;
            r_cfg.integ_gain      <= sdpb_pkg::INTEG_RST;
            r_cfg.deriv_gain      <= sdpb_pkg::DERIV_RST;
            r_cfg.decay_factor    <= sdpb_pkg::DECAY_RST;
            r_cfg.min_speed       <= sdpb_pkg::MIN_RST;
        end else if (i_cfg_we) begin
            unique case (sdpb_pkg::t_cfg_idx'(i_cfg_idx))
                sdpb_pkg::CFG_TARGET_TICKS: begin
                    r_cfg.target_ticks <= i_cfg_data[sdpb_pkg::TARGET_W-1:0];
                end
                sdpb_pkg::CFG_BASE_SPEED: begin
                    r_cfg.base_speed <= $signed(i_cfg_data[sdpb_pkg::BASE_W-1:0]);
                end
                sdpb_pkg::CFG_SLOW_ZONE_TICKS: begin
                    r_cfg.slow_zone_ticks <= i_cfg_data[sdpb_pkg::SLOW_W-1:0];
                end
                sdpb_pkg::CFG_PROP_GAIN: begin
                    r_cfg.prop_gain <= $signed(i_cfg_data[sdpb_pkg::GAIN_W-1:0]);
                end
                sdpb_pkg::CFG_INTEG_GAIN: begin
                    r_cfg.integ_gain <= $signed(i_cfg_data[sdpb_pkg::GAIN_W-1:0]);
                end
                sdpb_pkg::CFG_DERIV_GAIN: begin
                    r_cfg.deriv_gain <= $signed(i_cfg_data[sdpb_pkg::GAIN_W-1:0]);
                end
                sdpb_pkg::CFG_DECAY_FACTOR: begin
                    r_cfg.decay_factor <= i_cfg_data[sdpb_pkg::DECAY_W-1:0];
                end
                sdpb_pkg::CFG_MIN_SPEED: begin
                    r_cfg.min_speed <= i_cfg_data[sdpb_pkg::MIN_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/sdpb_err.sv
// Error stage: velocity error, integral and derivative state, PID products and distance tests.
`timescale 1ns / 1ps

module sdpb_err (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  sdpb_pkg::t_in_item i_item,
    input  sdpb_pkg::t_cfg     i_cfg,
    output sdpb_pkg::t_mid     o_mid
);

    localparam int VEL_W   = sdpb_pkg::VEL_W;
    localparam int ERR_W   = sdpb_pkg::ERR_W;
    localparam int DERIV_W = sdpb_pkg::DERIV_W;
    localparam int INTEG_W = sdpb_pkg::INTEG_W;
    localparam int POS_W   = sdpb_pkg::POS_W;
    localparam int DIST_W  = sdpb_pkg::DIST_W;
    localparam int PP_W    = sdpb_pkg::PROD_P_W;
    localparam int PI_W    = sdpb_pkg::PROD_I_W;
    localparam int PD_W    = sdpb_pkg::PROD_D_W;

    logic signed [POS_W-1:0]   r_start_pos;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_last_err;

    logic [VEL_W-1:0]          w_lv_mag;
    logic [VEL_W-1:0]          w_rv_mag;
    logic signed [ERR_W-1:0]   w_err;
    logic signed [INTEG_W:0]   w_integ_sum;
    logic signed [INTEG_W-1:0] w_integ;
    logic signed [DERIV_W-1:0] w_deriv;
    logic signed [POS_W-1:0]   w_trav;
    logic signed [DIST_W-1:0]  w_target;
    logic signed [DIST_W-1:0]  w_remain;

    // Error is the difference of the velocity magnitudes.
    assign w_lv_mag = i_item.left_velocity[VEL_W-1] ? VEL_W'(-i_item.left_velocity)
                                                    : VEL_W'(i_item.left_velocity);
    assign w_rv_mag = i_item.right_velocity[VEL_W-1] ? VEL_W'(-i_item.right_velocity)
                                                     : VEL_W'(i_item.right_velocity);
    assign w_err    = $signed({1'b0, w_lv_mag}) - $signed({1'b0, w_rv_mag});

    // Saturating integral and the derivative against the last error.
    assign w_integ_sum = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(w_err);
    always_comb begin
        if (w_integ_sum[INTEG_W] != w_integ_sum[INTEG_W-1]) begin
            w_integ = w_integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                           : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            w_integ = INTEG_W'(w_integ_sum);
        end
    end
    assign w_deriv = DERIV_W'(w_err) - DERIV_W'(r_last_err);

    // Distance since the latched start and the slow zone and target tests.
    assign w_trav   = i_item.encoder_position - r_start_pos;
    assign w_target = $signed({2'b00, i_cfg.target_ticks});
    assign w_remain = w_target - DIST_W'(w_trav);

    // Three independent products for the next stage.
    always_comb begin
        o_mid.op       = i_item.op;
        o_mid.traveled = w_trav;
        o_mid.slow     = w_remain < $signed({{(DIST_W-sdpb_pkg::SLOW_W){1'b0}},
                                             i_cfg.slow_zone_ticks});
        o_mid.reached  = DIST_W'(w_trav) >= w_target;
        o_mid.p_prop   = PP_W'(w_err) * PP_W'(i_cfg.prop_gain);
        o_mid.p_integ  = PI_W'(w_integ) * PI_W'(i_cfg.integ_gain);
        o_mid.p_deriv  = PD_W'(w_deriv) * PD_W'(i_cfg.deriv_gain);
    end

    // Start latches the position and clears the controller memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pos <= '0;
            r_integ     <= '0;
            r_last_err  <= '0;
        end else if (i_adv) begin
            if (i_item.op == sdpb_pkg::OP_START) begin
                r_start_pos <= i_item.encoder_position;
                r_integ     <= '0;
                r_last_err  <= '0;
            end else begin
                r_integ     <= w_integ;
                r_last_err  <= w_err;
            end
        end
    end

    // The stored error never leaves the magnitude range of the velocities.
    a_last_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_last_err <= sdpb_pkg::ERR_LIM) && (r_last_err >= -sdpb_pkg::ERR_LIM))
        else $error("last error out of range");

    // A start transfer clears the integral.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && (i_item.op == sdpb_pkg::OP_START) |=> (r_integ == '0) && (r_last_err == '0))
        else $error("integral not cleared by start");

endmodule

>>> rtl/core/sdpb_spd.sv
// Speed stage: PID offset, correction or decay of both side speeds, drive commands.
`timescale 1ns / 1ps

module sdpb_spd (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  sdpb_pkg::t_mid      i_mid,
    input  sdpb_pkg::t_cfg      i_cfg,
    output sdpb_pkg::t_out_item o_res
);

    localparam int SUM_W   = sdpb_pkg::SUM_W;
    localparam int FRAC_W  = sdpb_pkg::FRAC_W;
    localparam int OFFS_W  = sdpb_pkg::OFFS_W;
    localparam int STEP_W  = sdpb_pkg::STEP_W;
    localparam int CORR_W  = sdpb_pkg::CORR_W;
    localparam int SPEED_W = sdpb_pkg::SPEED_W;
    localparam int BASE_W  = sdpb_pkg::BASE_W;
    localparam int DPROD_W = sdpb_pkg::DPROD_W;

    logic signed [SPEED_W-1:0] r_left_q;
    logic signed [SPEED_W-1:0] r_right_q;
    logic                      r_running;

    logic signed [SUM_W-1:0]   w_sum;
    logic signed [SUM_W-1:0]   w_sum_adj;
    logic signed [SUM_W-1:0]   w_quot;
    logic signed [OFFS_W-1:0]  w_offs;
    logic signed [STEP_W-1:0]  w_step;
    logic signed [CORR_W-1:0]  w_right_corr;
    logic signed [CORR_W-1:0]  w_left_corr;
    logic signed [SPEED_W-1:0] w_left_nx;
    logic signed [SPEED_W-1:0] w_right_nx;
    logic signed [BASE_W-1:0]  w_base;
    logic signed [SPEED_W-1:0] w_base_q;

    // PID sum, divided by 256 toward zero and clamped.
    assign w_sum = SUM_W'(i_mid.p_prop) + SUM_W'(i_mid.p_integ) + SUM_W'(i_mid.p_deriv);
    assign w_sum_adj = w_sum[SUM_W-1] ? w_sum + SUM_W'((1 << FRAC_W) - 1) : w_sum;
    assign w_quot = w_sum_adj >>> FRAC_W;
    always_comb begin
        if (w_quot > SUM_W'(sdpb_pkg::OFFS_LIM)) begin
            w_offs = sdpb_pkg::OFFS_LIM;
        end else if (w_quot < -SUM_W'(sdpb_pkg::OFFS_LIM)) begin
            w_offs = -sdpb_pkg::OFFS_LIM;
        end else begin
            w_offs = OFFS_W'(w_quot);
        end
    end
    assign w_step = $signed({w_offs, {FRAC_W{1'b0}}});

    // Offset raises the right side and lowers the left side.
    assign w_right_corr = CORR_W'(r_right_q) + CORR_W'(w_step);
    assign w_left_corr  = CORR_W'(r_left_q) - CORR_W'(w_step);

    // Slow zone decays both speeds instead of correcting them.
    always_comb begin
        if (i_mid.slow) begin
            w_right_nx = sdpb_pkg::decay_one(r_right_q, i_cfg.decay_factor, i_cfg.min_speed);
            w_left_nx  = sdpb_pkg::decay_one(r_left_q, i_cfg.decay_factor, i_cfg.min_speed);
        end else begin
            w_right_nx = sdpb_pkg::sat_speed(DPROD_W'(w_right_corr));
            w_left_nx  = sdpb_pkg::sat_speed(DPROD_W'(w_left_corr));
        end
    end

    // Base speed, with the most negative code replaced by the next code up (-127).
    assign w_base   = (i_cfg.base_speed == sdpb_pkg::BASE_NEG) ? sdpb_pkg::BASE_MIN
                                                                : i_cfg.base_speed;
    assign w_base_q = $signed({w_base, {FRAC_W{1'b0}}});

    // Result of the transfer in this stage.
    always_comb begin
        o_res.left_drive     = '0;
        o_res.right_drive    = '0;
        o_res.traveled_ticks = i_mid.traveled;
        o_res.done_res       = 1'b0;
        if (i_mid.op == sdpb_pkg::OP_START) begin
            o_res.left_drive     = w_base;
            o_res.right_drive    = w_base;
            o_res.traveled_ticks = '0;
        end else if (r_running) begin
            if (i_mid.reached) begin
                o_res.done_res = 1'b1;
            end else begin
                o_res.left_drive  = sdpb_pkg::speed_to_drive(w_left_nx);
                o_res.right_drive = sdpb_pkg::speed_to_drive(w_right_nx);
            end
        end
    end

    // Speed and run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_q  <= '0;
            r_right_q <= '0;
            r_running <= 1'b0;
        end else if (i_adv) begin
            if (i_mid.op == sdpb_pkg::OP_START) begin
                r_left_q  <= w_base_q;
                r_right_q <= w_base_q;
                r_running <= 1'b1;
            end else if (r_running) begin
                r_left_q  <= w_left_nx;
                r_right_q <= w_right_nx;
                if (i_mid.reached) begin
                    r_running <= 1'b0;
                end
            end
        end
    end

    // Stored speeds stay inside the saturation limits.
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left_q <= sdpb_pkg::SPEED_LIM_Q) && (r_left_q >= -sdpb_pkg::SPEED_LIM_Q) &&
        (r_right_q <= sdpb_pkg::SPEED_LIM_Q) && (r_right_q >= -sdpb_pkg::SPEED_LIM_Q))
        else $error("speed outside saturation limits");

    // Reaching the target ends the run.
    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && (i_mid.op == sdpb_pkg::OP_SAMPLE) && r_running && i_mid.reached
        |=> !r_running)
        else $error("run continues after target reached");

endmodule

>>> rtl/core/straight_drive_pid_balancer.sv
// Straight-drive PID balancer top level: input register, error stage, speed stage, result register.
// An accepted item passes through the input register, the stage register and then the result register.
// Throughput: one item per cycle; the three-register pipeline advances whenever the
// result register is empty or its transfer completes, and freezes as a whole otherwise.
// Reset (synchronous, active low) clears pipeline valids, run state, speeds, integral,
// last error and start position, and loads register defaults.
`timescale 1ns / 1ps

module straight_drive_pid_balancer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  sdpb_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output sdpb_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [sdpb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sdpb_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    sdpb_pkg::t_cfg      w_cfg;
    sdpb_pkg::t_mid      w_mid;
    sdpb_pkg::t_out_item w_res;

    sdpb_pkg::t_in_item  r_s1;
    sdpb_pkg::t_mid      r_s2;
    sdpb_pkg::t_out_item r_out;
    logic                r_s1_valid;
    logic                r_s2_valid;
    logic                r_out_valid;
    logic                w_adv;

    // Whole pipeline moves when the result register can take a new transfer.
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_adv;

    sdpb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    sdpb_err u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv && r_s1_valid),
        .i_item  (r_s1),
        .i_cfg   (w_cfg),
        .o_mid   (w_mid)
    );

    sdpb_spd u_spd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv && r_s2_valid),
        .i_mid   (r_s2),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= i_in_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1  <= i_in_data;
            r_s2  <= w_mid;
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Input is held off only while a finished result waits.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result register");

    // A finished run reports zero drives.
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |->
        (o_out_data.left_drive == '0) && (o_out_data.right_drive == '0))
        else $error("nonzero drive on done result");

endmodule
